>>> rtl/preemptive_priority_task_scheduler_macros.svh
// Assertion macros for the preemptive priority task scheduler checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef PREEMPTIVE_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pps_pkg.sv
// Shared types and codes for the preemptive priority task scheduler.
// No dependencies; imported by the core, the result queue, the top and the checker.
package pps_pkg;

  // input opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result event codes
  localparam logic [2:0] EV_ADDED     = 3'd0;
  localparam logic [2:0] EV_REJECTED  = 3'd1;
  localparam logic [2:0] EV_STARTED   = 3'd2;
  localparam logic [2:0] EV_PREEMPTED = 3'd3;
  localparam logic [2:0] EV_ENDED     = 3'd4;

  // configuration register map, selected by paddr[2]
  localparam int         CFG_AW      = 3;
  localparam logic       REG_QUANTUM = 1'b0;
  localparam logic       REG_TOTAL   = 1'b1;
  localparam logic [7:0]  QUANTUM_RESET = 8'd5;
  localparam logic [15:0] TOTAL_RESET   = 16'd1;

  // result queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  typedef struct packed {
    logic [2:0]  res;
    logic [15:0] task_id;
    logic [5:0]  priority_lvl;
    logic [15:0] time_left;
    logic        last;
    logic [9:0]  queued;
    logic [15:0] ended;
    logic        all_done;
  } evt_t;

  // results produced by one item, r0 first
  typedef struct packed {
    logic [1:0] n;
    evt_t       r0;
    evt_t       r1;
  } res_push_t;

endpackage

>>> rtl/pps_store.sv
// Task store: one RAM holding all level FIFOs, entry = {id, remaining time}.
// Registered read with write-to-read forwarding; no dependencies.
module pps_store #(
  parameter int ENTRIES = 512,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [ENTRIES];
  logic [31:0] mem_q;
  logic [31:0] fwd_data;
  logic        fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q    <= mem[raddr];
    fwd_data <= wdata;
  end

  // the RAM returns old data on a same-address write; forward the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd_hit ? fwd_data : mem_q;

endmodule

>>> rtl/pps_core.sv
// Scheduler core: input register, per-level FIFO pointers, running task and counters.
// Uses pps_pkg; drives the task store ports and pushes results to the result queue.
module pps_core #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int QUEUE_DEPTH = 16,
  localparam int AW = $clog2(PRIORITY_LEVELS * QUEUE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [15:0]         task_id,
  input  logic [15:0]         task_duration,
  input  logic [5:0]          task_priority,
  input  logic [7:0]          quantum_len,
  input  logic [15:0]         total_tasks,
  input  logic                room,
  input  logic [31:0]         head_data,
  output logic                we,
  output logic [AW-1:0]       waddr,
  output logic [31:0]         wdata,
  output logic [AW-1:0]       raddr,
  output pps_pkg::res_push_t  push
);

  import pps_pkg::*;

  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int QW = $clog2(PRIORITY_LEVELS * QUEUE_DEPTH + 1);

  // input register
  logic        item_valid;
  logic        item_op;
  logic [15:0] item_id;
  logic [15:0] item_dur;
  logic [5:0]  item_pri;
  logic        go;

  // FIFO pointers
  logic [HW-1:0] head [PRIORITY_LEVELS];
  logic [HW-1:0] head_next [PRIORITY_LEVELS];
  logic [CW-1:0] count [PRIORITY_LEVELS];
  logic [CW-1:0] count_next [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] mask_cur;
  logic [PRIORITY_LEVELS-1:0] mask_next;
  logic [LW-1:0] best_cur;
  logic [LW-1:0] best_next;

  // running task and counters
  logic          run_valid, run_valid_next;
  logic [15:0]   run_id, run_id_next;
  logic [15:0]   run_left, run_left_next;
  logic [LW-1:0] run_pri, run_pri_next;
  logic [QW-1:0] queued, queued_next, queued_pop;
  logic [15:0]   ended, ended_next;

  // per-item working signals
  logic          disp;
  logic          pri_ok;
  logic [LW-1:0] lvl_add;
  logic          cur_valid;
  logic [15:0]   cur_id;
  logic [15:0]   cur_left;
  logic [LW-1:0] cur_pri;
  logic [15:0]   left_sub;
  logic          urgent;
  logic          push_en;
  logic [LW-1:0] push_lvl;
  logic [15:0]   push_id;
  logic [15:0]   push_left;
  logic [SW-1:0] slot_sum;
  logic [HW-1:0] slot;
  logic          a_v, b_v;
  evt_t          ev_a, ev_b;

  function automatic logic [LW-1:0] first_set(input logic [PRIORITY_LEVELS-1:0] m);
    logic [LW-1:0] r;
    r = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (m[i]) r = LW'(i);
    end
    return r;
  endfunction

  assign go       = item_valid && room;
  assign in_stall = item_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_op  <= opcode;
      item_id  <= task_id;
      item_dur <= task_duration;
      item_pri <= task_priority;
    end
  end

  always_comb begin
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      mask_cur[i]  = (count[i] != '0);
      mask_next[i] = (count_next[i] != '0);
    end
  end

  assign best_cur  = first_set(mask_cur);
  assign best_next = first_set(mask_next);

  always_comb begin
    head_next      = head;
    count_next     = count;
    run_valid_next = run_valid;
    run_id_next    = run_id;
    run_left_next  = run_left;
    run_pri_next   = run_pri;
    queued_next    = queued;
    queued_pop     = queued;
    ended_next     = ended;
    disp           = 1'b0;
    pri_ok         = 1'b0;
    lvl_add        = '0;
    cur_valid      = run_valid;
    cur_id         = run_id;
    cur_left       = run_left;
    cur_pri        = run_pri;
    left_sub       = '0;
    urgent         = 1'b0;
    push_en        = 1'b0;
    push_lvl       = '0;
    push_id        = item_id;
    push_left      = item_dur;
    slot_sum       = '0;
    slot           = '0;
    a_v            = 1'b0;
    b_v            = 1'b0;
    ev_a           = '0;
    ev_b           = '0;
    if (go) begin
      if (item_op == OP_ADD) begin
        pri_ok = (item_pri != '0) && (7'(item_pri) <= 7'(PRIORITY_LEVELS));
        if (pri_ok) lvl_add = LW'(item_pri - 6'd1);
        push_en  = pri_ok && (item_dur != '0) && (count[lvl_add] != CW'(QUEUE_DEPTH));
        push_lvl = lvl_add;
        a_v      = 1'b1;
        ev_a.res          = push_en ? EV_ADDED : EV_REJECTED;
        ev_a.task_id      = item_id;
        ev_a.priority_lvl = item_pri;
        ev_a.time_left    = item_dur;
      end else begin
        // dispatch from the prefetched head of the most urgent level
        disp = !run_valid && (mask_cur != '0);
        if (disp) begin
          head_next[best_cur]  = (head[best_cur] == HW'(QUEUE_DEPTH - 1)) ? '0
                                 : head[best_cur] + 1'b1;
          count_next[best_cur] = count[best_cur] - 1'b1;
          queued_pop           = queued - 1'b1;
          queued_next          = queued_pop;
          cur_valid = 1'b1;
          cur_id    = head_data[31:16];
          cur_left  = head_data[15:0];
          cur_pri   = best_cur;
          a_v       = 1'b1;
          ev_a.res          = EV_STARTED;
          ev_a.task_id      = cur_id;
          ev_a.priority_lvl = 6'(32'(cur_pri) + 32'd1);
          ev_a.time_left    = cur_left;
        end
        if (cur_valid) begin
          run_id_next  = cur_id;
          run_pri_next = cur_pri;
          b_v = 1'b0;
          ev_b.task_id      = cur_id;
          ev_b.priority_lvl = 6'(32'(cur_pri) + 32'd1);
          if (cur_left <= {8'd0, quantum_len}) begin
            run_valid_next = 1'b0;
            run_left_next  = '0;
            if (ended != 16'hFFFF) ended_next = ended + 16'd1;
            b_v            = 1'b1;
            ev_b.res       = EV_ENDED;
            ev_b.time_left = '0;
          end else begin
            left_sub       = cur_left - {8'd0, quantum_len};
            run_valid_next = 1'b1;
            run_left_next  = left_sub;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
              if ((count_next[i] != '0) && (LW'(i) < cur_pri)) urgent = 1'b1;
            end
            // move back to the tail unless the own FIFO is full
            if (urgent && (count_next[cur_pri] != CW'(QUEUE_DEPTH))) begin
              push_en        = 1'b1;
              push_lvl       = cur_pri;
              push_id        = cur_id;
              push_left      = left_sub;
              run_valid_next = 1'b0;
              b_v            = 1'b1;
              ev_b.res       = EV_PREEMPTED;
              ev_b.time_left = left_sub;
            end
          end
        end
      end
      if (push_en) begin
        slot_sum = SW'(head_next[push_lvl]) + SW'(count_next[push_lvl]);
        slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                   : HW'(slot_sum);
        count_next[push_lvl] = count_next[push_lvl] + 1'b1;
        queued_next          = queued_next + 1'b1;
      end
    end
    ev_a.queued   = (item_op == OP_ADD) ? 10'(queued_next) : 10'(queued_pop);
    ev_a.ended    = ended;
    ev_a.all_done = (ended == total_tasks);
    ev_b.queued   = 10'(queued_next);
    ev_b.ended    = ended_next;
    ev_b.all_done = (ended_next == total_tasks);
  end

  assign we    = push_en;
  assign waddr = AW'(AW'(push_lvl) * AW'(QUEUE_DEPTH) + AW'(slot));
  assign wdata = {push_id, push_left};
  // prefetch the head of the level that will be most urgent after this cycle
  assign raddr = AW'(AW'(best_next) * AW'(QUEUE_DEPTH) + AW'(head_next[best_next]));

  always_comb begin
    push = '0;
    if (a_v && b_v) begin
      push.n  = 2'd2;
      push.r0 = ev_a;
      push.r1 = ev_b;
      push.r1.last = 1'b1;
    end else if (a_v || b_v) begin
      push.n  = 2'd1;
      push.r0 = a_v ? ev_a : ev_b;
      push.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      run_valid <= 1'b0;
      run_id    <= '0;
      run_left  <= '0;
      run_pri   <= '0;
      queued    <= '0;
      ended     <= '0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      run_valid <= run_valid_next;
      run_id    <= run_id_next;
      run_left  <= run_left_next;
      run_pri   <= run_pri_next;
      queued    <= queued_next;
      ended     <= ended_next;
    end
  end

endmodule

>>> rtl/pps_outq.sv
// Result queue: four-entry buffer taking up to two results per cycle, one out when not stalled.
// Uses pps_pkg for the result type and queue geometry.
module pps_outq (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::res_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::evt_t      head_evt
);

  import pps_pkg::*;

  evt_t             slots [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_AW:0]   fill;
  logic             pop;

  assign out_valid = (fill != '0);
  assign pop       = out_valid && !out_stall;
  // an item may need two slots
  assign room      = (fill <= (OQ_AW + 1)'(OQ_DEPTH - 2));
  assign head_evt  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slots[wr_ptr + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push.n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (OQ_AW + 1)'(push.n) - (OQ_AW + 1)'(pop);
    end
  end

endmodule

>>> rtl/preemptive_priority_task_scheduler.sv
// Preemptive priority task scheduler. Items are add or tick commands; each is
// taken into an input register and processed from there once the result queue
// has room, so one item can be accepted per cycle while the queue has room; its
// results are written to the result queue, whose head drives the outputs.
// The task store is a single RAM with a registered read; the head of the most
// urgent waiting level is prefetched through that read, so a dispatch need not
// wait for the RAM. A tick that starts a task and then ends or preempts it
// gives two results, which drain through a four-entry result queue at one per
// cycle unless the output stalls; input stalls while fewer than two queue slots
// are free. The store needs no clearing after reset.
// Configuration: quantum_len at byte address 0, total_tasks at address 4.
module preemptive_priority_task_scheduler #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic [15:0]                task_id,
  input  logic [15:0]                task_duration,
  input  logic [5:0]                 task_priority,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 event_res,
  output logic [15:0]                event_task_id,
  output logic [5:0]                 event_priority,
  output logic [15:0]                time_left,
  output logic                       last_result,
  output logic [9:0]                 tasks_queued,
  output logic [15:0]                tasks_ended,
  output logic                       all_done,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pps_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import pps_pkg::*;

  localparam int ENTRIES = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(ENTRIES);

  logic [7:0]    quantum_len;
  logic [15:0]   total_tasks;
  logic          cfg_wr;
  logic          room;
  logic [31:0]   head_data;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   wdata;
  res_push_t     push;
  evt_t          head_evt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_len <= QUANTUM_RESET;
      total_tasks <= TOTAL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_QUANTUM: quantum_len <= pwdata[7:0];
        REG_TOTAL:   total_tasks <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_QUANTUM: prdata = {24'd0, quantum_len};
      REG_TOTAL:   prdata = {16'd0, total_tasks};
      default:     prdata = '0;
    endcase
  end

  pps_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (head_data)
  );

  pps_core #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .task_id       (task_id),
    .task_duration (task_duration),
    .task_priority (task_priority),
    .quantum_len   (quantum_len),
    .total_tasks   (total_tasks),
    .room          (room),
    .head_data     (head_data),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata),
    .raddr         (raddr),
    .push          (push)
  );

  pps_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head_evt  (head_evt)
  );

  assign event_res      = head_evt.res;
  assign event_task_id  = head_evt.task_id;
  assign event_priority = head_evt.priority_lvl;
  assign time_left      = head_evt.time_left;
  assign last_result    = head_evt.last;
  assign tasks_queued   = head_evt.queued;
  assign tasks_ended    = head_evt.ended;
  assign all_done       = head_evt.all_done;

endmodule

>>> rtl/pps_checker.sv
// Port-level checker for the preemptive priority task scheduler, bound to the top.
// Uses pps_pkg event codes and the assertion macros header.
`include "preemptive_priority_task_scheduler_macros.svh"

module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_res,
  input logic [15:0] time_left,
  input logic        last_result,
  input logic [15:0] tasks_ended
);

  import pps_pkg::*;

  // a stalled result holds
  `PPS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_res) && $stable(time_left) && $stable(tasks_ended), "stalled result changed")

  // an ended task has no time left and has been counted
  `PPS_ASSERT_IMP(a_end_counted, out_valid && event_res == EV_ENDED, time_left == 16'd0 && tasks_ended != 16'd0, "ended result with time left or zero count")

  // an add gives exactly one result
  `PPS_ASSERT_IMP(a_add_single, out_valid && (event_res == EV_ADDED || event_res == EV_REJECTED), last_result, "add result not marked last")

  // zero-length tasks never reach the running slot
  `PPS_ASSERT_IMP(a_start_nonzero, out_valid && event_res == EV_STARTED, time_left != 16'd0, "started task with no run time")

endmodule

bind preemptive_priority_task_scheduler pps_checker u_pps_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_res   (event_res),
  .time_left   (time_left),
  .last_result (last_result),
  .tasks_ended (tasks_ended)
);
